@@ design/sbg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_pkg
// Shared types, request codes and arithmetic helpers for the spherical
// bispectrum and gradient core.
// ----------------------------------------------------------------------------
package sbg_pkg;

	localparam int CgDepth = 131072;
	localparam int CgAw    = 17;
	localparam int QDepth  = 2;
	localparam int QPtrW   = 1;

	localparam logic [1:0] REQ_LOAD_COEF = 2'd0;
	localparam logic [1:0] REQ_LOAD_CG   = 2'd1;
	localparam logic [1:0] REQ_BISPEC    = 2'd2;
	localparam logic [1:0] REQ_GRAD      = 2'd3;

	localparam logic [1:0] ROLE_ONE   = 2'd0;
	localparam logic [1:0] ROLE_TWO   = 2'd1;
	localparam logic [1:0] ROLE_TOTAL = 2'd2;

	localparam logic [1:0] PASS_SIDE1 = 2'd0;
	localparam logic [1:0] PASS_SIDE2 = 2'd1;
	localparam logic [1:0] PASS_TOTAL = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [2:0]         degree_one;
		logic [2:0]         degree_two;
		logic [2:0]         degree_total;
		logic signed [3:0]  order_m;
		logic signed [3:0]  order_m1;
		logic [1:0]         target_role;
		logic signed [23:0] value_re;
		logic signed [23:0] value_im;
	} in_item_t;

	typedef struct packed {
		logic               status;
		logic [9:0]         row_index;
		logic [6:0]         col_index;
		logic signed [47:0] first_value;
		logic signed [47:0] second_value;
		logic signed [47:0] third_value;
		logic signed [47:0] fourth_value;
	} out_item_t;

	// classified request as queued between front and back
	typedef struct packed {
		in_item_t   item;
		logic       err;
		logic [9:0] row;
		logic [6:0] col;
		logic       use_total;
		logic       use_two;
		logic       use_one;
	} q_entry_t;

	function automatic logic [7:0] coef_addr(logic [2:0] deg, logic [3:0] ord);
		logic [7:0] base;
		base = {5'd0, deg} * {5'd0, deg} + {5'd0, deg};
		return base + {{4{ord[3]}}, ord};
	endfunction

	function automatic logic [CgAw-1:0] cg_addr(logic [2:0] l1, logic [2:0] l2,
			logic [2:0] lt, logic [3:0] m, logic [3:0] m1);
		return {l1, l2, lt, m, m1};
	endfunction

	// round half up from Q.40 to Q.20
	function automatic logic signed [28:0] round_q20(logic signed [48:0] v);
		logic signed [48:0] t;
		t = v + 49'sd524288;
		return $signed(t[48:20]);
	endfunction

	function automatic logic signed [47:0] sat48(logic signed [63:0] v);
		logic signed [47:0] r;
		if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
			r = 48'sh7FFF_FFFF_FFFF;
		end else if (v < -64'sh0000_8000_0000_0000) begin
			r = -48'sh8000_0000_0000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ design/sbg_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_front
// Accepts requests, checks the degree triple and target, walks the triple
// list to find the row and hands the classified request to the queue.
// ----------------------------------------------------------------------------
module sbg_front import sbg_pkg::*; #(
	parameter int MAX_BANDLIMIT = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	input  logic [2:0] bandlimit,
	output logic       q_push,
	output q_entry_t   q_data,
	input  logic       q_full
);

	localparam logic [4:0] MaxBl = 5'(MAX_BANDLIMIT);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_ROW  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t    state_q;
	q_entry_t   ent_q;
	logic [2:0] a_q, b_q;

	logic [2:0]        lim, l1, l2, lt, d;
	logic              is_req, is_grad, bad_tri, bad_ord, err;
	logic signed [4:0] n5, d5;
	logic [7:0]        colv;
	logic [3:0]        ab, top, amb, dl;
	logic [4:0]        cnt;
	logic              hit;

	assign lim = ({2'b00, bandlimit} > MaxBl) ? MaxBl[2:0] : bandlimit;

	always_comb begin
		l1      = in_item.degree_one;
		l2      = in_item.degree_two;
		lt      = in_item.degree_total;
		is_req  = in_item.req_type == REQ_BISPEC || in_item.req_type == REQ_GRAD;
		is_grad = in_item.req_type == REQ_GRAD;
		bad_tri = (l2 > l1) || ({1'b0, lt} + {1'b0, l2} < {1'b0, l1})
			|| ({1'b0, lt} > {1'b0, l1} + {1'b0, l2}) || (l1 > lim) || (lt > lim);
		case (in_item.target_role)
			ROLE_ONE: d = l1;
			ROLE_TWO: d = l2;
			default:  d = lt;
		endcase
		n5      = {in_item.order_m[3], in_item.order_m};
		d5      = $signed({2'b00, d});
		bad_ord = (n5 > d5) || (n5 < -d5);
		err     = is_req && (bad_tri || (is_grad
			&& (in_item.target_role == REQ_GRAD || bad_ord)));
		colv    = {5'd0, d} * {5'd0, d} + {5'd0, d} + {{4{n5[4]}}, n5[3:0]};
	end

	// one (l1', l2') pair of the triple list per cycle
	always_comb begin
		hit = a_q == ent_q.item.degree_one && b_q == ent_q.item.degree_two;
		ab  = {1'b0, a_q} + {1'b0, b_q};
		top = (ab > {1'b0, lim}) ? {1'b0, lim} : ab;
		amb = {1'b0, a_q} - {1'b0, b_q};
		cnt = {1'b0, top} - {1'b0, amb} + 5'd1;
		dl  = {1'b0, ent_q.item.degree_total}
			- ({1'b0, ent_q.item.degree_one} - {1'b0, ent_q.item.degree_two});
	end

	assign in_ready = state_q == F_IDLE;
	assign q_push   = state_q == F_PUSH && !q_full;
	assign q_data   = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) begin
					state_q <= (is_req && !err) ? F_ROW : F_PUSH;
				end
				F_ROW: if (hit) begin
					state_q <= F_PUSH;
				end
				F_PUSH: if (!q_full) begin
					state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			ent_q.item      <= in_item;
			ent_q.err       <= err;
			ent_q.row       <= '0;
			ent_q.col       <= (is_grad && !err) ? {colv[5:0], 1'b0} : '0;
			ent_q.use_one   <= l1 == d;
			ent_q.use_two   <= l2 == d;
			ent_q.use_total <= lt == d;
			a_q             <= '0;
			b_q             <= '0;
		end else if (state_q == F_ROW) begin
			if (hit) begin
				ent_q.row <= ent_q.row + {5'd0, dl, 1'b0};
			end else begin
				ent_q.row <= ent_q.row + {4'd0, cnt, 1'b0};
				if (b_q == a_q) begin
					a_q <= a_q + 3'd1;
					b_q <= '0;
				end else begin
					b_q <= b_q + 3'd1;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ design/sbg_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_fifo
// Short queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module sbg_fifo import sbg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	input  logic     pop,
	output q_entry_t head,
	output logic     full,
	output logic     empty
);

	q_entry_t         mem_q [QDepth];
	logic [QPtrW-1:0] wr_q, rd_q;
	logic [QPtrW:0]   cnt_q;

	assign full  = cnt_q == (QPtrW+1)'(QDepth);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

@@ design/sbg_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbg_back
// Holds the coefficient and CG stores, performs loads and runs the shared
// complex multiply-accumulate sequencer for bispectrum and gradient requests.
// ----------------------------------------------------------------------------
module sbg_back import sbg_pkg::*; #(
	parameter int MAX_BANDLIMIT = 7
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  q_entry_t  q_head,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	localparam int CoefDepth = (MAX_BANDLIMIT + 1) * (MAX_BANDLIMIT + 1);
	localparam int CoefAw    = $clog2(CoefDepth);

	typedef enum logic [11:0] {
		B_IDLE = 12'b0000_0000_0001,
		B_PASS = 12'b0000_0000_0010,
		B_INIT = 12'b0000_0000_0100,
		B_RD   = 12'b0000_0000_1000,
		B_MUL  = 12'b0000_0001_0000,
		B_GMUL = 12'b0000_0010_0000,
		B_ACC  = 12'b0000_0100_0000,
		B_FRD  = 12'b0000_1000_0000,
		B_FLO  = 12'b0001_0000_0000,
		B_FHI  = 12'b0010_0000_0000,
		B_FACC = 12'b0100_0000_0000,
		B_OUT  = 12'b1000_0000_0000
	} bstate_t;

	bstate_t state_q;
	q_entry_t cur_q;
	logic [2:0] pend_q;
	logic [1:0] pass_q;
	logic signed [4:0] qord_q, k_q, hi_q;
	logic signed [47:0] p1_q, p2_q, p3_q, p4_q;
	logic signed [52:0] tr_q, ti_q;
	logic signed [63:0] hr_q, hi_acc_q, ar_q, ai_q;
	logic signed [43:0] sr_q, si_q;
	logic signed [49:0] u1_q, u2_q, u3_q, u4_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [47:0] coef_mem [CoefDepth];
	logic [23:0] cg_mem [CgDepth];
	logic [47:0] x_rd_q, y_rd_q;
	logic [23:0] g_rd_q;

	// ---------------- addressing ----------------
	logic [2:0] l1, l2, lt, a_deg, b_deg;
	logic bisp, tot, side1;
	logic signed [4:0] n_ord, a5, b5, lo, hi, y_ord, g_m, g_m1, nlo, nhi;
	logic [CoefAw-1:0] x_addr, y_addr, w_addr;
	logic [CgAw-1:0] g_addr;
	logic rd_en;

	always_comb begin
		l1    = cur_q.item.degree_one;
		l2    = cur_q.item.degree_two;
		lt    = cur_q.item.degree_total;
		bisp  = cur_q.item.req_type == REQ_BISPEC;
		tot   = pass_q == PASS_TOTAL;
		side1 = pass_q == PASS_SIDE1;
		n_ord = bisp ? qord_q : {cur_q.item.order_m[3], cur_q.item.order_m};
		a_deg = tot ? l1 : lt;
		b_deg = (pass_q == PASS_SIDE2) ? l1 : l2;
		a5    = $signed({2'b00, a_deg});
		b5    = $signed({2'b00, b_deg});
		nlo   = n_ord - b5;
		nhi   = n_ord + b5;
		lo    = (nlo > -a5) ? nlo : -a5;
		hi    = (nhi < a5) ? nhi : a5;
		y_ord = tot ? n_ord - k_q : k_q - n_ord;
		g_m   = tot ? n_ord : k_q;
		g_m1  = tot ? k_q : (side1 ? n_ord : k_q - n_ord);
		x_addr = (state_q == B_FRD) ? CoefAw'(coef_addr(lt, qord_q[3:0]))
			: CoefAw'(coef_addr(a_deg, k_q[3:0]));
		y_addr = CoefAw'(coef_addr(b_deg, y_ord[3:0]));
		g_addr = cg_addr(l1, l2, lt, g_m[3:0], g_m1[3:0]);
		rd_en  = state_q == B_RD || state_q == B_FRD;
		w_addr = CoefAw'(coef_addr(q_head.item.degree_total, q_head.item.order_m));
	end

	// ---------------- load handling ----------------
	logic head_coef, head_cg, head_err, coef_ok;
	logic signed [4:0] wm5, wl5;

	always_comb begin
		head_coef = !q_empty && q_head.item.req_type == REQ_LOAD_COEF;
		head_cg   = !q_empty && q_head.item.req_type == REQ_LOAD_CG;
		head_err  = !q_empty && q_head.err && !head_coef && !head_cg;
		wm5       = {q_head.item.order_m[3], q_head.item.order_m};
		wl5       = $signed({2'b00, q_head.item.degree_total});
		coef_ok   = (int'(q_head.item.degree_total) <= MAX_BANDLIMIT)
			&& (wm5 >= -wl5) && (wm5 <= wl5);
		q_pop     = state_q == B_IDLE && !q_empty && (head_coef || head_cg
			|| !out_valid_q || !head_err);
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && head_coef && coef_ok) begin
			coef_mem[w_addr] <= {q_head.item.value_re, q_head.item.value_im};
		end
		if (rd_en) begin
			x_rd_q <= coef_mem[x_addr];
			y_rd_q <= coef_mem[y_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && head_cg) begin
			cg_mem[cg_addr(q_head.item.degree_one, q_head.item.degree_two,
				q_head.item.degree_total, q_head.item.order_m,
				q_head.item.order_m1)] <= q_head.item.value_re;
		end
		if (rd_en) begin
			g_rd_q <= cg_mem[g_addr];
		end
	end

	// ---------------- arithmetic ----------------
	logic signed [23:0] xr, xi, yr, yi, gv;
	logic signed [48:0] e_re, e_im;
	logic signed [28:0] r_re, r_im;
	logic signed [63:0] rnd_r, rnd_i;
	logic signed [25:0] opr, opi;
	logic signed [63:0] v0, v1, v2, v3;

	always_comb begin
		xr    = $signed(x_rd_q[47:24]);
		xi    = $signed(x_rd_q[23:0]);
		yr    = $signed(y_rd_q[47:24]);
		yi    = $signed(y_rd_q[23:0]);
		gv    = $signed(g_rd_q);
		e_re  = tot ? 49'(p1_q) - 49'(p2_q) : 49'(p1_q) + 49'(p2_q);
		e_im  = tot ? 49'(p3_q) + 49'(p4_q) : 49'(p4_q) - 49'(p3_q);
		r_re  = round_q20(e_re);
		r_im  = round_q20(e_im);
		rnd_r = hr_q + 64'sd524288;
		rnd_i = hi_acc_q + 64'sd524288;
		// low 18 bits of S as unsigned digit, then the signed high part
		if (state_q == B_FLO) begin
			opr = $signed({8'd0, sr_q[17:0]});
			opi = $signed({8'd0, si_q[17:0]});
		end else begin
			opr = $signed(sr_q[43:18]);
			opi = $signed(si_q[43:18]);
		end
		if (bisp) begin
			v0 = ar_q;
			v1 = ai_q;
			v2 = '0;
			v3 = '0;
		end else begin
			v0 = hr_q + ar_q;
			v1 = hi_acc_q + ai_q;
			v2 = ai_q - hi_acc_q;
			v3 = hr_q - ar_q;
		end
	end

	// ---------------- control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: if (q_pop && !head_coef && !head_cg) begin
					if (q_head.err) begin
						out_valid_q <= 1'b1;
					end else begin
						state_q <= B_PASS;
						pend_q  <= (q_head.item.req_type == REQ_BISPEC) ? 3'b100
							: {q_head.use_total, q_head.use_two, q_head.use_one};
					end
				end
				B_PASS: begin
					if (pend_q[0]) begin
						pend_q[0] <= 1'b0;
						state_q   <= B_INIT;
					end else if (pend_q[1]) begin
						pend_q[1] <= 1'b0;
						state_q   <= B_INIT;
					end else if (pend_q[2]) begin
						pend_q[2] <= 1'b0;
						state_q   <= B_INIT;
					end else begin
						state_q <= B_OUT;
					end
				end
				B_INIT: state_q <= B_RD;
				B_RD:   state_q <= B_MUL;
				B_MUL:  state_q <= B_GMUL;
				B_GMUL: state_q <= B_ACC;
				B_ACC: begin
					if (k_q != hi_q) begin
						state_q <= B_RD;
					end else begin
						state_q <= bisp ? B_FRD : B_PASS;
					end
				end
				B_FRD: state_q <= B_FLO;
				B_FLO: state_q <= B_FHI;
				B_FHI: state_q <= B_FACC;
				B_FACC: begin
					if (qord_q == $signed({2'b00, lt})) begin
						state_q <= B_OUT;
					end else begin
						pend_q  <= 3'b100;
						state_q <= B_PASS;
					end
				end
				B_OUT: if (!out_valid_q) begin
					out_valid_q <= 1'b1;
					state_q     <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_pop && !head_coef && !head_cg) begin
					cur_q    <= q_head;
					hr_q     <= '0;
					hi_acc_q <= '0;
					ar_q     <= '0;
					ai_q     <= '0;
					qord_q   <= -$signed({2'b00, q_head.item.degree_total});
					if (q_head.err) begin
						out_q <= '{status: 1'b1, row_index: '0, col_index: '0,
							first_value: '0, second_value: '0, third_value: '0,
							fourth_value: '0};
					end
				end
			end
			B_PASS: begin
				if (pend_q[0]) begin
					pass_q <= PASS_SIDE1;
				end else if (pend_q[1]) begin
					pass_q <= PASS_SIDE2;
				end else begin
					pass_q <= PASS_TOTAL;
				end
			end
			B_INIT: begin
				k_q  <= lo;
				hi_q <= hi;
				if (bisp) begin
					hr_q     <= '0;
					hi_acc_q <= '0;
				end
			end
			B_MUL: begin
				p1_q <= xr * yr;
				p2_q <= xi * yi;
				p3_q <= xr * yi;
				p4_q <= xi * yr;
			end
			B_GMUL: begin
				tr_q <= gv * r_re;
				ti_q <= gv * r_im;
			end
			B_ACC: begin
				if (tot) begin
					hr_q     <= hr_q + 64'(tr_q);
					hi_acc_q <= hi_acc_q - 64'(ti_q);
				end else begin
					ar_q <= ar_q + 64'(tr_q);
					ai_q <= ai_q + 64'(ti_q);
				end
				k_q <= k_q + 5'sd1;
			end
			B_FRD: begin
				sr_q <= $signed(rnd_r[63:20]);
				si_q <= $signed(rnd_i[63:20]);
			end
			B_FLO: begin
				u1_q <= xr * opr;
				u2_q <= xi * opi;
				u3_q <= xi * opr;
				u4_q <= xr * opi;
			end
			B_FHI: begin
				ar_q <= ar_q + 64'(u1_q) - 64'(u2_q);
				ai_q <= ai_q + 64'(u3_q) + 64'(u4_q);
				u1_q <= xr * opr;
				u2_q <= xi * opi;
				u3_q <= xi * opr;
				u4_q <= xr * opi;
			end
			B_FACC: begin
				ar_q   <= ar_q + ((64'(u1_q) - 64'(u2_q)) <<< 18);
				ai_q   <= ai_q + ((64'(u3_q) + 64'(u4_q)) <<< 18);
				qord_q <= qord_q + 5'sd1;
			end
			B_OUT: begin
				if (!out_valid_q) begin
					out_q.status       <= 1'b0;
					out_q.row_index    <= cur_q.row;
					out_q.col_index    <= cur_q.col;
					out_q.first_value  <= sat48(v0);
					out_q.second_value <= sat48(v1);
					out_q.third_value  <= sat48(v2);
					out_q.fourth_value <= sat48(v3);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule
`default_nettype wire

@@ design/spherical_bispectrum_and_gradient_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spherical_bispectrum_and_gradient_core
// Fixed-point spherical-harmonic bispectrum entries and gradient blocks.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_ready carry one request per transaction: coefficient load,
//    CG load, bispectrum entry or gradient block. Loads give no result.
//  - out_valid/out_ready carry one result per bispectrum or gradient request,
//    in request order. Rejected requests return status 1 with zero fields.
//  - cfg_we/cfg_wdata write bandlimit_in_use (reset 7); write only when idle.
//  - The front checks the request and walks the triple list for the row,
//    one (l1,l2) pair per cycle, then queues it.
//  - The back runs one shared complex MAC: each inner term is read (RD),
//    multiplied (MUL), scaled by its CG value (GMUL) and accumulated (ACC);
//    each order q of a bispectrum entry then adds a final MAC with its coefficient.
//    A gradient block runs these steps per term of each summed pass.
//  - Loads are applied by the back in queue order.
//  - A stalled receiver holds the output register; the back waits, the queue
//    fills, then in_ready drops. Reset empties queue and output; the stores
//    are not cleared and hold no defined value until written.
// ----------------------------------------------------------------------------
module spherical_bispectrum_and_gradient_core import sbg_pkg::*; #(
	parameter int MAX_BANDLIMIT = 7
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item,
	input  logic      cfg_we,
	input  logic [2:0] cfg_wdata
);

	logic [2:0] bandlimit_q;
	logic       q_push, q_pop, q_full, q_empty;
	q_entry_t   q_data, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bandlimit_q <= 3'd7;
		end else if (cfg_we) begin
			bandlimit_q <= cfg_wdata;
		end
	end

	sbg_front #(.MAX_BANDLIMIT(MAX_BANDLIMIT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.bandlimit (bandlimit_q),
		.q_push    (q_push),
		.q_data    (q_data),
		.q_full    (q_full)
	);

	sbg_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	sbg_back #(.MAX_BANDLIMIT(MAX_BANDLIMIT)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("front took a second transaction while busy");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status |-> out_item.first_value == '0
		&& out_item.row_index == '0 && out_item.col_index == '0)
		else $error("rejected result carries nonzero fields");

endmodule
`default_nettype wire

@@ test/tb_spherical_bispectrum_and_gradient_core.sv @@
// ----------------------------------------------------------------------------
// tb_spherical_bispectrum_and_gradient_core
// Loads coefficient and Clebsch-Gordan stores, then issues directed and
// random bispectrum and gradient requests. Each result is checked field by
// field against an in-bench fixed-point predictor, under random idling on
// both channels, a long output stall and several bandlimit settings.
// ----------------------------------------------------------------------------
module tb_spherical_bispectrum_and_gradient_core;
	import sbg_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE      = 120;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_item;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_item;
	logic      cfg_we;
	logic [2:0] cfg_wdata;

	spherical_bispectrum_and_gradient_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state
	int        coef_re [64];
	int        coef_im [64];
	int        cg_mem [CgDepth];
	bit        cg_set [CgDepth];
	int        band_lim;
	bit        dry_run;
	int        missing_cg[$];
	out_item_t pending_results[$];

	int errors;
	int cycles;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor
	function automatic int cg_index(int l1, int l2, int lt, int m, int m1);
		return ((l1 & 7) << 14) | ((l2 & 7) << 11) | ((lt & 7) << 8) | ((m & 15) << 4)
			| (m1 & 15);
	endfunction

	function automatic longint cg_rd(int l1, int l2, int lt, int m, int m1);
		int a;
		a = cg_index(l1, l2, lt, m, m1);
		if (!cg_set[a]) begin
			if (dry_run) missing_cg.push_back(a);
			return 0;
		end
		return cg_mem[a];
	endfunction

	function automatic longint rnd20(longint v);
		return (v + (64'sd1 <<< 19)) >>> 20;
	endfunction

	function automatic logic [47:0] clip48(longint v);
		if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'h7FFF_FFFF_FFFF;
		if (v < -64'sh0000_8000_0000_0000) return 48'h8000_0000_0000;
		return v[47:0];
	endfunction

	function automatic int imax(int a, int b);
		return a > b ? a : b;
	endfunction

	function automatic int imin(int a, int b);
		return a < b ? a : b;
	endfunction

	function automatic void triple_sum(int l1, int l2, int lt, int n,
			output longint sr, output longint si);
		longint ar, ai, cr, ci, g;
		sr = 0;
		si = 0;
		for (int m1 = imax(-l1, n - l2); m1 <= imin(l1, n + l2); m1++) begin
			ar = coef_re[l1*(l1+1)+m1];
			ai = coef_im[l1*(l1+1)+m1];
			cr = coef_re[l2*(l2+1)+n-m1];
			ci = coef_im[l2*(l2+1)+n-m1];
			g = cg_rd(l1, l2, lt, n, m1);
			sr += g * rnd20(ar*cr - ai*ci);
			si -= g * rnd20(ar*ci + ai*cr);
		end
	endfunction

	function automatic void partner_sum(int l1, int l2, int lt, int n, bit second,
			output longint sr, output longint si);
		int oth;
		longint xr, xi, yr, yi, g;
		oth = second ? l1 : l2;
		sr = 0;
		si = 0;
		for (int m = imax(-lt, n - oth); m <= imin(lt, n + oth); m++) begin
			xr = coef_re[lt*(lt+1)+m];
			xi = coef_im[lt*(lt+1)+m];
			yr = coef_re[oth*(oth+1)+m-n];
			yi = coef_im[oth*(oth+1)+m-n];
			g = second ? cg_rd(l1, l2, lt, m, m - n) : cg_rd(l1, l2, lt, m, n);
			sr += g * rnd20(xr*yr + xi*yi);
			si += g * rnd20(xi*yr - xr*yi);
		end
	endfunction

	function automatic int triple_row(int l1, int l2, int lt, int lim);
		int idx;
		idx = 0;
		for (int a = 0; a <= lim; a++)
			for (int b = 0; b <= a; b++)
				for (int c = a - b; c <= a + b && c <= lim; c++) begin
					if (a == l1 && b == l2 && c == lt) return idx & 10'h3FF;
					idx += 2;
				end
		return idx & 10'h3FF;
	endfunction

	// returns 1 when the item produces a result
	function automatic bit predict_result(in_item_t it, output out_item_t r);
		int l1, l2, lt, n, m1, d;
		longint sr, si, fr, fi, br, bi, hr, hi, ar, ai;
		longint v[4];
		r = '0;
		l1 = it.degree_one;
		l2 = it.degree_two;
		lt = it.degree_total;
		n = it.order_m;
		m1 = it.order_m1;
		if (it.req_type == REQ_LOAD_COEF) begin
			if (n >= -lt && n <= lt) begin
				coef_re[lt*(lt+1)+n] = it.value_re;
				coef_im[lt*(lt+1)+n] = it.value_im;
			end
			return 0;
		end
		if (it.req_type == REQ_LOAD_CG) begin
			cg_mem[cg_index(l1, l2, lt, n, m1)] = it.value_re;
			cg_set[cg_index(l1, l2, lt, n, m1)] = 1'b1;
			return 0;
		end
		if (l2 > l1 || lt < l1 - l2 || lt > l1 + l2 || l1 > band_lim || lt > band_lim) begin
			r.status = 1'b1;
			return 1;
		end
		v = '{0, 0, 0, 0};
		if (it.req_type == REQ_BISPEC) begin
			br = 0;
			bi = 0;
			for (int q = -lt; q <= lt; q++) begin
				triple_sum(l1, l2, lt, q, sr, si);
				sr = rnd20(sr);
				si = rnd20(si);
				fr = coef_re[lt*(lt+1)+q];
				fi = coef_im[lt*(lt+1)+q];
				br += fr*sr - fi*si;
				bi += fi*sr + fr*si;
			end
			v[0] = br;
			v[1] = bi;
		end else begin
			if (it.target_role > ROLE_TOTAL) begin
				r.status = 1'b1;
				return 1;
			end
			d = it.target_role == ROLE_ONE ? l1 : (it.target_role == ROLE_TWO ? l2 : lt);
			if (n < -d || n > d) begin
				r.status = 1'b1;
				return 1;
			end
			hr = 0; hi = 0; ar = 0; ai = 0;
			if (l1 == d) begin
				partner_sum(l1, l2, lt, n, 1'b0, sr, si);
				ar += sr; ai += si;
			end
			if (l2 == d) begin
				partner_sum(l1, l2, lt, n, 1'b1, sr, si);
				ar += sr; ai += si;
			end
			if (lt == d) begin
				triple_sum(l1, l2, lt, n, sr, si);
				hr += sr; hi += si;
			end
			v[0] = hr + ar;
			v[1] = hi + ai;
			v[2] = ai - hi;
			v[3] = hr - ar;
			r.col_index = (2 * (d*(d+1) + n)) & 7'h7F;
		end
		r.row_index = triple_row(l1, l2, lt, band_lim);
		r.first_value = clip48(v[0]);
		r.second_value = clip48(v[1]);
		r.third_value = clip48(v[2]);
		r.fourth_value = clip48(v[3]);
		return 1;
	endfunction

	// ---------------------------------------------------------------- drivers
	function automatic logic [23:0] rand_value();
		logic signed [23:0] raw;
		raw = $urandom();
		return raw >>> $urandom_range(0, 12);
	endfunction

	task automatic send_item(in_item_t it);
		out_item_t r;
		int gap;
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		if (predict_result(it, r)) pending_results.push_back(r);
		gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// loads any CG entries the request would read that were never written
	task automatic issue(in_item_t it);
		out_item_t r;
		in_item_t ld;
		if (it.req_type == REQ_BISPEC || it.req_type == REQ_GRAD) begin
			missing_cg.delete();
			dry_run = 1'b1;
			void'(predict_result(it, r));
			dry_run = 1'b0;
			foreach (missing_cg[i]) begin
				if (!cg_set[missing_cg[i]]) begin
					ld = '0;
					ld.req_type = REQ_LOAD_CG;
					{ld.degree_one, ld.degree_two, ld.degree_total, ld.order_m, ld.order_m1}
						= missing_cg[i][16:0];
					ld.value_re = rand_value();
					ld.value_im = $urandom();
					send_item(ld);
				end
			end
		end
		send_item(it);
	endtask

	function automatic in_item_t make_req(logic [1:0] req, int l1, int l2, int lt, int n,
			logic [1:0] role);
		in_item_t it;
		it = '0;
		it.req_type = req;
		it.degree_one = l1;
		it.degree_two = l2;
		it.degree_total = lt;
		it.order_m = n;
		it.order_m1 = $urandom();
		it.target_role = role;
		it.value_re = $urandom();
		it.value_im = $urandom();
		return it;
	endfunction

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_band(int v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		band_lim = v;
	endtask

	// ---------------------------------------------------------------- result check
	always @(posedge clk) begin
		out_item_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, out_item);
			end else begin
				e = pending_results.pop_front();
				if (out_item.status !== e.status)
					$display("%0t: status exp %0d got %0d", $time, e.status, out_item.status);
				if (out_item.row_index !== e.row_index)
					$display("%0t: row exp %0d got %0d", $time, e.row_index, out_item.row_index);
				if (out_item.col_index !== e.col_index)
					$display("%0t: col exp %0d got %0d", $time, e.col_index, out_item.col_index);
				if (out_item.first_value !== e.first_value)
					$display("%0t: first exp %0d got %0d", $time, e.first_value,
						out_item.first_value);
				if (out_item.second_value !== e.second_value)
					$display("%0t: second exp %0d got %0d", $time, e.second_value,
						out_item.second_value);
				if (out_item.third_value !== e.third_value)
					$display("%0t: third exp %0d got %0d", $time, e.third_value,
						out_item.third_value);
				if (out_item.fourth_value !== e.fourth_value)
					$display("%0t: fourth exp %0d got %0d", $time, e.fourth_value,
						out_item.fourth_value);
				if (out_item !== e) errors++;
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- tests
	task automatic test_coef_preload();
		in_item_t it;
		for (int l = 0; l <= 7; l++)
			for (int m = -l; m <= l; m++) begin
				it = make_req(REQ_LOAD_COEF, $urandom, $urandom, l, m, $urandom);
				it.value_re = rand_value();
				it.value_im = rand_value();
				issue(it);
			end
	endtask

	task automatic test_directed();
		in_item_t it;
		// extreme coefficient values at degree 1
		it = make_req(REQ_LOAD_COEF, 0, 0, 1, -1, 0);
		it.value_re = 24'h7FFFFF;
		it.value_im = 24'h800000;
		issue(it);
		it = make_req(REQ_LOAD_COEF, 0, 0, 1, 1, 0);
		it.value_re = 24'h800000;
		it.value_im = 24'h800000;
		issue(it);
		// out-of-range order on a coefficient load is dropped
		issue(make_req(REQ_LOAD_COEF, 0, 0, 2, 5, 0));
		issue(make_req(REQ_LOAD_COEF, 0, 0, 0, -8, 0));
		issue(make_req(REQ_BISPEC, 0, 0, 0, 0, 0));
		issue(make_req(REQ_BISPEC, 1, 1, 2, 0, 0));
		issue(make_req(REQ_BISPEC, 7, 7, 7, 0, 0));
		issue(make_req(REQ_BISPEC, 7, 0, 7, 0, 0));
		// malformed triples
		issue(make_req(REQ_BISPEC, 1, 2, 1, 0, 0));
		issue(make_req(REQ_BISPEC, 5, 1, 3, 0, 0));
		issue(make_req(REQ_GRAD, 2, 1, 4, 0, ROLE_ONE));
		// all three roles coincide
		issue(make_req(REQ_GRAD, 3, 3, 3, -2, ROLE_ONE));
		issue(make_req(REQ_GRAD, 2, 1, 3, 1, ROLE_TWO));
		issue(make_req(REQ_GRAD, 2, 1, 3, -3, ROLE_TOTAL));
		issue(make_req(REQ_GRAD, 7, 7, 0, 0, ROLE_TOTAL));
		// bad gradient target or order, then a valid order at the edge
		issue(make_req(REQ_GRAD, 2, 1, 3, 0, 2'd3));
		issue(make_req(REQ_GRAD, 2, 1, 3, 2, ROLE_TWO));
		issue(make_req(REQ_GRAD, 7, 7, 7, -8, ROLE_ONE));
		issue(make_req(REQ_GRAD, 7, 7, 7, 7, ROLE_ONE));
	endtask

	function automatic in_item_t random_item(int lmax);
		in_item_t it;
		int l1, l2, lt, d;
		logic [1:0] role;
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			it = '0;
			it = {$urandom, $urandom, $urandom, $urandom};
			return it;
		end
		l1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(0, lmax);
		l2 = $urandom_range(0, l1);
		lt = $urandom_range(l1 - l2, imin(l1 + l2, 7));
		if (sel < 30) begin
			d = $urandom_range(0, 7);
			it = make_req(REQ_LOAD_COEF, l1, l2, d, $urandom_range(0, 2*d) - d, 0);
			it.value_re = rand_value();
			it.value_im = rand_value();
			return it;
		end
		if (sel < 62) return make_req(REQ_BISPEC, l1, l2, lt, 0, 0);
		role = $urandom_range(0, 2);
		d = role == ROLE_ONE ? l1 : (role == ROLE_TWO ? l2 : lt);
		return make_req(REQ_GRAD, l1, l2, lt, $urandom_range(0, 2*d) - d, role);
	endfunction

	task automatic test_bandlimit();
		write_band(0);
		issue(make_req(REQ_BISPEC, 0, 0, 0, 0, 0));
		issue(make_req(REQ_BISPEC, 1, 1, 0, 0, 0));
		issue(make_req(REQ_GRAD, 0, 0, 0, 0, ROLE_TOTAL));
		write_band(3);
		for (int i = 0; i < 12; i++) issue(random_item(4));
		write_band(7);
	endtask

	task automatic test_random();
		int pct[3][2];
		pct = '{'{27, 76}, '{76, 27}, '{0, 0}};
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = pct[p][0];
			recv_idle_pct = pct[p][1];
			if (p == 1) write_band($urandom_range(1, 6));
			if (p == 2) write_band(7);
			for (int i = 0; i < 150; i++) issue(random_item(3));
		end
	endtask

	task automatic test_backpressure();
		hold_off = 600;
		for (int i = 0; i < 12; i++) issue(make_req(REQ_BISPEC, 1, 0, 1, 0, 0));
		// sender waits for everything outstanding
		drain();
		for (int i = 0; i < 8; i++) issue(random_item(2));
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_off = 0;
		dry_run = 1'b0;
		band_lim = 7;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_item <= '0;
		out_ready <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coef_preload();
		test_directed();
		test_bandlimit();
		test_random();
		test_backpressure();
		drain();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
